/* sv/assert_macros.svh */
// Assertion helpers included by the RTL of the list block (indexed_array_list_core).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define IAL_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define IAL_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

/* sv/ial_pkg.sv */
package ial_pkg;

    localparam int IAL_CAPACITY   = 32;
    localparam int IAL_WORD_WIDTH = 32;
    localparam int IAL_ACT_W      = 3;
    localparam int IAL_POS_W      = 5;
    localparam int IAL_IO_WORD_W  = 32;
    localparam int IAL_COUNT_W    = 6;

    typedef enum logic [IAL_ACT_W-1:0] {
        ACT_APPEND = 3'd0,
        ACT_INSERT = 3'd1,
        ACT_GET    = 3'd2,
        ACT_REMOVE = 3'd3,
        ACT_POP    = 3'd4
    } t_ial_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_INDEX = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_ial_status;

    typedef enum logic [1:0] {
        SH_NONE   = 2'd0,
        SH_APPEND = 2'd1,
        SH_INSERT = 2'd2,
        SH_REMOVE = 2'd3
    } t_ial_shift;

    typedef struct packed {
        t_ial_action                action;
        logic [IAL_POS_W-1:0]       position;
        logic [IAL_IO_WORD_W-1:0]   word_in;
    } t_ial_req;

    typedef struct packed {
        logic [IAL_IO_WORD_W-1:0]   word_out;
        t_ial_status                status;
        logic [IAL_COUNT_W-1:0]     count;
    } t_ial_rsp;

endpackage

/* sv/ial_cell.sv */
module ial_cell #(
    parameter int IDX        = 0,
    parameter int WORD_WIDTH = ial_pkg::IAL_WORD_WIDTH,
    parameter int CMPW       = ial_pkg::IAL_POS_W
) (
    input  logic                  i_clk,
    input  ial_pkg::t_ial_shift   i_op,
    input  logic [CMPW-1:0]       i_pos,
    input  logic [CMPW-1:0]       i_held,
    input  logic [WORD_WIDTH-1:0] i_word,
    input  logic [WORD_WIDTH-1:0] i_left,
    input  logic [WORD_WIDTH-1:0] i_right,
    output logic [WORD_WIDTH-1:0] o_word,
    output logic [WORD_WIDTH-1:0] o_rd
);
    import ial_pkg::*;

    localparam logic [CMPW-1:0] L_IDX = CMPW'(IDX);

    logic [WORD_WIDTH-1:0] r_word;
    logic [WORD_WIDTH-1:0] n_word;

    always_comb begin
        n_word = r_word;
        unique case (i_op)
            SH_NONE: begin
                n_word = r_word;
            end
            SH_APPEND: begin
                if (L_IDX == i_held) begin
                    n_word = i_word;
                end
            end
            SH_INSERT: begin
                if (L_IDX == i_pos) begin
                    n_word = i_word;
                end else if (L_IDX > i_pos) begin
                    n_word = i_left;
                end
            end
            SH_REMOVE: begin
                if (L_IDX >= i_pos) begin
                    n_word = i_right;
                end
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;
    assign o_rd   = (L_IDX == i_pos) ? r_word : '0;

endmodule

/* sv/indexed_array_list_core.sv */
// Channel   | Signals                 | Handshake
// request   | i_req (t_ial_req)       | start high while busy low
// result    | o_rsp (t_ial_rsp)       | o_done high for one cycle
//
// A request is taken when start is high; its result appears with o_done in the next cycle.
// Shifts for insert and remove happen at once across the row of entry cells, each
// shifted cell taking its word from a neighbor or, at the insert position, from the
// request, so busy stays low and a request may follow in every cycle.
// Reset clears the entry count and the result strobe; entry contents are not cleared.
// The receiver cannot stall the result.
module indexed_array_list_core #(
    parameter int CAPACITY   = ial_pkg::IAL_CAPACITY,
    parameter int WORD_WIDTH = ial_pkg::IAL_WORD_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ial_pkg::t_ial_req i_req,
    output logic              o_done,
    output ial_pkg::t_ial_rsp o_rsp
);
    import ial_pkg::*;

    `include "assert_macros.svh"

    localparam int HW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (HW > IAL_POS_W) ? HW : IAL_POS_W;

    logic [HW-1:0]         r_held;
    logic [HW-1:0]         n_held;
    logic                  r_done;
    t_ial_rsp              r_rsp;
    t_ial_rsp              n_rsp;
    t_ial_shift            op;
    logic [CMPW-1:0]       pos_ext;
    logic [CMPW-1:0]       held_ext;
    logic                  full;
    logic                  pos_ok;
    logic [WORD_WIDTH-1:0] word_st;
    logic [WORD_WIDTH-1:0] rd_or;
    logic [WORD_WIDTH-1:0] rd_word;
    logic [WORD_WIDTH-1:0] cell_word [CAPACITY];
    logic [WORD_WIDTH-1:0] cell_rd   [CAPACITY];
    logic [WORD_WIDTH-1:0] cell_left [CAPACITY];
    logic [WORD_WIDTH-1:0] cell_right[CAPACITY];
    logic [CMPW+IAL_POS_W-1:0]          pos_wide;
    logic [CMPW+HW-1:0]                 held_wide;
    logic [WORD_WIDTH+IAL_IO_WORD_W-1:0] in_wide;
    logic [WORD_WIDTH+IAL_IO_WORD_W-1:0] out_wide;
    logic [HW+IAL_COUNT_W-1:0]          cnt_wide;

    function automatic logic [IAL_COUNT_W-1:0] cnt_hold(input logic [HW-1:0] h);
        logic [HW+IAL_COUNT_W-1:0] w;
        w = {{IAL_COUNT_W{1'b0}}, h};
        return w[IAL_COUNT_W-1:0];
    endfunction

    assign busy = 1'b0;

    assign pos_wide  = {{CMPW{1'b0}}, i_req.position};
    assign held_wide = {{CMPW{1'b0}}, r_held};
    assign pos_ext   = pos_wide[CMPW-1:0];
    assign held_ext  = held_wide[CMPW-1:0];
    assign in_wide   = {{WORD_WIDTH{1'b0}}, i_req.word_in};
    assign word_st   = in_wide[WORD_WIDTH-1:0];
    assign full      = (r_held == HW'(CAPACITY));
    assign pos_ok    = (pos_ext < held_ext);

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign cell_left[g] = word_st;
            end else begin : g_inner
                assign cell_left[g] = cell_word[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign cell_right[g] = cell_word[g];
            end else begin : g_body
                assign cell_right[g] = cell_word[g+1];
            end
            ial_cell #(
                .IDX       (g),
                .WORD_WIDTH(WORD_WIDTH),
                .CMPW      (CMPW)
            ) u_cell (
                .i_clk  (i_clk),
                .i_op   (op),
                .i_pos  (pos_ext),
                .i_held (held_ext),
                .i_word (word_st),
                .i_left (cell_left[g]),
                .i_right(cell_right[g]),
                .o_word (cell_word[g]),
                .o_rd   (cell_rd[g])
            );
        end
    endgenerate

    always_comb begin
        rd_or = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            rd_or = rd_or | cell_rd[k];
        end
    end

    always_comb begin
        op          = SH_NONE;
        n_held      = r_held;
        rd_word     = '0;
        n_rsp.status = ST_OK;
        unique case (i_req.action)
            ACT_APPEND: begin
                if (full) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    op     = SH_APPEND;
                    n_held = r_held + 1'b1;
                end
            end
            ACT_INSERT: begin
                if (!pos_ok) begin
                    n_rsp.status = ST_INDEX;
                end else if (full) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    op     = SH_INSERT;
                    n_held = r_held + 1'b1;
                end
            end
            ACT_GET: begin
                if (!pos_ok) begin
                    n_rsp.status = ST_INDEX;
                end else begin
                    rd_word = rd_or;
                end
            end
            ACT_REMOVE: begin
                if (!pos_ok) begin
                    n_rsp.status = ST_INDEX;
                end else begin
                    op     = SH_REMOVE;
                    n_held = r_held - 1'b1;
                end
            end
            ACT_POP: begin
                if (r_held == '0) begin
                    n_rsp.status = ST_EMPTY;
                end else begin
                    n_held = r_held - 1'b1;
                end
            end
            default: begin
                n_rsp.status = ST_OK;
            end
        endcase
        if (!start) begin
            op     = SH_NONE;
            n_held = r_held;
        end
        out_wide       = {{IAL_IO_WORD_W{1'b0}}, rd_word};
        cnt_wide       = {{IAL_COUNT_W{1'b0}}, n_held};
        n_rsp.word_out = out_wide[IAL_IO_WORD_W-1:0];
        n_rsp.count    = cnt_wide[IAL_COUNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_done <= 1'b0;
        end else begin
            r_held <= n_held;
            r_done <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    `IAL_ASSERT_ALWAYS(a_held_cap, r_held <= HW'(CAPACITY), "entry count above capacity")
    `IAL_ASSERT_NEXT(a_done_follows, start && !busy, o_done, "accepted request gave no result")
    `IAL_ASSERT_NEXT(a_no_spurious, !start, !o_done, "result without a request")
    `IAL_ASSERT_ALWAYS(a_word_on_error, !o_done || o_rsp.status == ST_OK || o_rsp.word_out == '0,
        "read word not zero on error")
    `IAL_ASSERT_ALWAYS(a_count_match, !o_done || o_rsp.count == cnt_hold(r_held),
        "reported count differs from entry count")

endmodule
